// ===== rtl/core/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants for the serial byte receiver (8 data bits,
// even parity, one line sample per tick).
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int TICK_BITS  = 20;
  localparam int CFG_W      = 20;
  localparam int FRAME_BITS = 9;
  localparam int BIT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GUARD    = 2'd2;

  localparam logic [CFG_W-1:0] START_OFFSET_RST = 20'd150000;
  localparam logic [CFG_W-1:0] BIT_PERIOD_RST   = 20'd100000;
  localparam logic [CFG_W-1:0] END_GUARD_RST    = 20'd150000;

  typedef struct packed {
    logic [CFG_W-1:0] start_offset;
    logic [CFG_W-1:0] bit_period;
    logic [CFG_W-1:0] end_guard;
  } sbr_cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       parity_error;
  } sbr_result_t;

endpackage

// ===== rtl/core/sbr_in_if.sv =====
// ----------------------------------------------------------------------------
// sbr_in_if
// Line sample channel: valid/ready handshake carrying one rx_level sample.
// ----------------------------------------------------------------------------
interface sbr_in_if;
  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink (input valid, input rx_level, output ready);
endinterface

// ===== rtl/core/sbr_out_if.sv =====
// ----------------------------------------------------------------------------
// sbr_out_if
// Result channel: valid/ready handshake carrying one received byte.
// ----------------------------------------------------------------------------
interface sbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       parity_error;

  modport source (output valid, output rx_byte, output parity_error, input ready);
  modport sink (input valid, input rx_byte, input parity_error, output ready);
endinterface

// ===== rtl/core/sbr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sbr_cfg_regs
// Timing registers: start offset, bit period and end guard, written by index.
// ----------------------------------------------------------------------------
module sbr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbr_pkg::CFG_W-1:0]     cfg_data,
  output sbr_pkg::sbr_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_offset <= sbr_pkg::START_OFFSET_RST;
      cfg.bit_period   <= sbr_pkg::BIT_PERIOD_RST;
      cfg.end_guard    <= sbr_pkg::END_GUARD_RST;
    end else if (cfg_we) begin
      // indexes past the list are dropped
      case (cfg_index)
        sbr_pkg::CFG_START_OFFSET: cfg.start_offset <= cfg_data;
        sbr_pkg::CFG_BIT_PERIOD:   cfg.bit_period   <= cfg_data;
        sbr_pkg::CFG_END_GUARD:    cfg.end_guard    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// sbr_frame_fsm
// Frame sequencer: start detection, timed bit sampling, parity tracking,
// stop wait and end guard. Advances by one tick per transferred sample.
// ----------------------------------------------------------------------------
module sbr_frame_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  rx_level,
  input  sbr_pkg::sbr_cfg_t     cfg,
  output logic                  emit,
  output sbr_pkg::sbr_result_t  result
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BITS  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_GUARD = 3'd4
  } phase_t;

  phase_t                             phase, phase_next;
  logic [sbr_pkg::TICK_BITS-1:0]      tick_count, tick_count_next;
  logic [sbr_pkg::BIT_IDX_W-1:0]      bit_index, bit_index_next;
  logic [sbr_pkg::FRAME_BITS-1:0]     frame_shift, frame_shift_next;
  logic                               ones_parity, ones_parity_next;
  logic                               tick_done;
  logic [sbr_pkg::TICK_BITS-1:0]      tick_dec;

  assign tick_done = (tick_count <= sbr_pkg::TICK_BITS'(1));
  assign tick_dec  = tick_count - sbr_pkg::TICK_BITS'(1);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    frame_shift_next = frame_shift;
    ones_parity_next = ones_parity;
    emit             = 1'b0;

    if (ones_parity) begin
      result.rx_byte      = 8'd0;
      result.parity_error = 1'b1;
    end else begin
      result.rx_byte      = frame_shift[8:1];
      result.parity_error = 1'b0;
    end

    case (phase)
      PH_START, PH_BITS: begin
        if (!tick_done) begin
          tick_count_next = tick_dec;
        end else begin
          tick_count_next = '0;
          if (bit_index < sbr_pkg::BIT_IDX_W'(sbr_pkg::FRAME_BITS)) begin
            frame_shift_next = {frame_shift[sbr_pkg::FRAME_BITS-2:0], rx_level};
            ones_parity_next = ones_parity ^ rx_level;
            bit_index_next   = bit_index + sbr_pkg::BIT_IDX_W'(1);
            tick_count_next  = cfg.bit_period;
            phase_next       = PH_BITS;
          end else if (rx_level) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_HIGH;
          end
        end
      end
      PH_HIGH: begin
        if (rx_level) emit = 1'b1;
      end
      PH_GUARD: begin
        if (tick_done) begin
          tick_count_next = '0;
          phase_next      = PH_IDLE;
        end else begin
          tick_count_next = tick_dec;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (!rx_level) begin
          phase_next       = PH_START;
          tick_count_next  = cfg.start_offset;
          bit_index_next   = '0;
          frame_shift_next = '0;
          ones_parity_next = 1'b0;
        end
      end
    endcase

    // result leaves: load the guard wait, skip it when zero
    if (emit) begin
      tick_count_next = cfg.end_guard;
      phase_next      = (cfg.end_guard == '0) ? PH_IDLE : PH_GUARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      frame_shift <= '0;
      ones_parity <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      frame_shift <= frame_shift_next;
      ones_parity <= ones_parity_next;
    end
  end

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= sbr_pkg::BIT_IDX_W'(sbr_pkg::FRAME_BITS))
    else $error("bit index past frame length");

  a_bits_after_first: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BITS) |-> (bit_index != '0))
    else $error("bit wait with no sample taken");

  a_emit_full_frame: assert property (@(posedge clk) disable iff (rst)
    emit |-> (bit_index == sbr_pkg::BIT_IDX_W'(sbr_pkg::FRAME_BITS)))
    else $error("result before nine samples");

endmodule

// ===== rtl/core/sbr_out_stage.sv =====
// ----------------------------------------------------------------------------
// sbr_out_stage
// Result register with valid/ready: holds one received byte until transfer.
// ----------------------------------------------------------------------------
module sbr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sbr_pkg::sbr_result_t result,
  output logic                 busy,
  sbr_out_if.source            out
);

  logic                 valid;
  sbr_pkg::sbr_result_t data;

  // slot is free when empty or drained this cycle
  assign busy = valid && !out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= result;
  end

  assign out.valid        = valid;
  assign out.rx_byte      = data.rx_byte;
  assign out.parity_error = data.parity_error;

  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(valid) |-> $past(load))
    else $error("result valid without a load");

  a_parity_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (valid && data.parity_error) |-> (data.rx_byte == 8'd0))
    else $error("byte not cleared on parity error");

endmodule

// ===== rtl/core/serial_byte_receiver_even_parity.sv =====
// ----------------------------------------------------------------------------
// serial_byte_receiver_even_parity
// Serial receiver, 8 data bits plus even parity, one line sample per transfer.
// Output: the output register takes the result on the transfer of the
//   sample that completes the frame.
// Throughput: one sample per cycle; input stalls only while a result waits.
// Reset (rst, synchronous): idle, counters cleared, registers at defaults.
// ----------------------------------------------------------------------------
module serial_byte_receiver_even_parity (
  input  logic                          clk,
  input  logic                          rst,
  sbr_in_if.sink                        rx_in,
  sbr_out_if.source                     rx_out,
  input  logic                          cfg_we,
  input  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbr_pkg::CFG_W-1:0]     cfg_data
);

  sbr_pkg::sbr_cfg_t    cfg;
  sbr_pkg::sbr_result_t result;
  logic                 step;
  logic                 emit;
  logic                 busy;

  assign rx_in.ready = !busy;
  assign step        = rx_in.valid && rx_in.ready;

  sbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbr_frame_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_level (rx_in.rx_level),
    .cfg      (cfg),
    .emit     (emit),
    .result   (result)
  );

  sbr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && emit),
    .result (result),
    .busy   (busy),
    .out    (rx_out)
  );

endmodule

// ===== tb/sv/serial_byte_receiver_even_parity_tb.sv =====
// ----------------------------------------------------------------------------
// serial_byte_receiver_even_parity_tb
// Self-checking bench for the serial byte receiver. A sample-level predictor
// tracks start detection, bit sampling, stop wait and guard time. A frame
// generator steers the line from the predicted state, so frames land on the
// sample ticks for any timing setting. A directed table runs first, then
// random frames, broken frames and line noise with random handshake stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_byte_receiver_even_parity_tb;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RAND_SAMPLES  = 900;
  localparam int          DIR_ROWS      = 14;

  localparam logic [sbr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [sbr_pkg::CFG_W-1:0]     CFG_MAX    = 20'hFFFFF;

  typedef enum logic [2:0] {
    RX_IDLE      = 3'd0,
    RX_START     = 3'd1,
    RX_BITS      = 3'd2,
    RX_WAIT_HIGH = 3'd3,
    RX_GUARD     = 3'd4
  } rx_phase_t;

  typedef struct packed {
    logic [sbr_pkg::CFG_W-1:0] start_off;
    logic [sbr_pkg::CFG_W-1:0] bit_per;
    logic [sbr_pkg::CFG_W-1:0] guard;
    logic                      has_frame;
    logic [8:0]                frame;
    logic [3:0]                late_stop;
    logic                      typed;
    logic [7:0]                want_byte;
    logic                      want_perr;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sbr_pkg::CFG_W-1:0]     cfg_data;

  sbr_in_if  rx_in();
  sbr_out_if rx_out();

  serial_byte_receiver_even_parity i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_in     (rx_in),
    .rx_out    (rx_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and its copy of the registers
  rx_phase_t                 m_phase;
  logic [19:0]               m_ticks;
  logic [3:0]                m_bit;
  logic [8:0]                m_shift;
  logic                      m_par;
  logic [sbr_pkg::CFG_W-1:0] m_start_off;
  logic [sbr_pkg::CFG_W-1:0] m_bit_per;
  logic [sbr_pkg::CFG_W-1:0] m_guard;

  sbr_pkg::sbr_result_t      bytes_due[$];
  sbr_pkg::sbr_result_t      got_want;
  dir_row_t                  dir_rows[DIR_ROWS];

  int unsigned samples_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          tail_quiet;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Count one tick of the running wait; true when the wait ends here.
  function automatic bit wait_done();
    if (m_ticks <= 1) begin
      m_ticks = '0;
      return 1'b1;
    end
    m_ticks = m_ticks - 1'b1;
    return 1'b0;
  endfunction

  function automatic void close_frame(output sbr_pkg::sbr_result_t res);
    res.rx_byte      = m_par ? 8'h00 : m_shift[8:1];
    res.parity_error = m_par;
    m_ticks          = m_guard;
    m_phase          = (m_ticks == 0) ? RX_IDLE : RX_GUARD;
  endfunction

  function automatic bit predict_sample(input logic level,
                                        output sbr_pkg::sbr_result_t res);
    res = '0;
    case (m_phase)
      RX_START, RX_BITS: begin
        if (!wait_done()) return 1'b0;
        if (m_bit < sbr_pkg::FRAME_BITS) begin
          m_shift = {m_shift[7:0], level};
          m_par   = m_par ^ level;
          m_bit   = m_bit + 1'b1;
          m_ticks = m_bit_per;
          m_phase = RX_BITS;
          return 1'b0;
        end
        if (level) begin
          close_frame(res);
          return 1'b1;
        end
        m_phase = RX_WAIT_HIGH;
      end
      RX_WAIT_HIGH: begin
        if (level) begin
          close_frame(res);
          return 1'b1;
        end
      end
      RX_GUARD: begin
        if (wait_done()) m_phase = RX_IDLE;
      end
      default: begin
        m_phase = RX_IDLE;
        if (!level) begin
          m_phase = RX_START;
          m_ticks = m_start_off;
          m_bit   = '0;
          m_shift = '0;
          m_par   = 1'b0;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------ sender

  task automatic send_level(input logic level, output bit produced);
    sbr_pkg::sbr_result_t res;
    int unsigned          gap;
    if (!tail_quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 17);
      repeat (gap) begin
        @(negedge clk);
        rx_in.valid    <= 1'b0;
        rx_in.rx_level <= ($urandom_range(0, 1) == 1);
      end
    end
    @(negedge clk);
    rx_in.valid    <= 1'b1;
    rx_in.rx_level <= level;
    do @(posedge clk); while (rx_in.ready !== 1'b1);
    samples_sent++;
    produced = predict_sample(level, res);
    if (produced) bytes_due.push_back(res);
  endtask

  task automatic send_line(input int unsigned n, input bit noisy);
    bit d;
    repeat (n) send_level(noisy ? ($urandom_range(0, 1) == 1) : 1'b1, d);
  endtask

  // Steer the line from the predicted state: start low, each frame bit on its
  // sample tick, stop held low for late_stop ticks. A nonzero cut abandons the
  // frame after that many samples.
  task automatic send_frame(input logic [8:0] bits, input int unsigned late_stop,
                            input bit noisy, input int unsigned cut);
    int unsigned sent;
    int unsigned low_left;
    logic        level;
    bit          in_bits;
    bit          at_stop;
    bit          done;
    sent     = 0;
    low_left = late_stop;
    done     = 1'b0;
    while (!done && (cut == 0 || sent < cut)) begin
      in_bits = (m_phase == RX_START) || (m_phase == RX_BITS);
      at_stop = (m_phase == RX_WAIT_HIGH) ||
                (in_bits && m_ticks <= 1 && m_bit >= sbr_pkg::FRAME_BITS);
      if (m_phase == RX_IDLE) begin
        level = 1'b0;
      end else if (at_stop) begin
        level = (low_left == 0);
        if (low_left != 0) low_left--;
      end else if (in_bits && m_ticks <= 1) begin
        level = bits[sbr_pkg::FRAME_BITS - 1 - m_bit];
      end else if (noisy) begin
        level = ($urandom_range(0, 1) == 1);
      end else if (m_phase == RX_START) begin
        level = 1'b0;
      end else if (in_bits && m_bit < sbr_pkg::FRAME_BITS) begin
        level = bits[sbr_pkg::FRAME_BITS - 1 - m_bit];
      end else begin
        level = 1'b1;
      end
      send_level(level, done);
      sent++;
    end
  endtask

  // Hold the line high until the predicted receiver is back to idle.
  task automatic finish_frames();
    bit d;
    while (m_phase != RX_IDLE) send_level(1'b1, d);
  endtask

  task automatic drain();
    @(negedge clk);
    rx_in.valid <= 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbr_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      sbr_pkg::CFG_START_OFFSET: m_start_off = data;
      sbr_pkg::CFG_BIT_PERIOD:   m_bit_per   = data;
      sbr_pkg::CFG_END_GUARD:    m_guard     = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [sbr_pkg::CFG_W-1:0] start_off,
                            input logic [sbr_pkg::CFG_W-1:0] bit_per,
                            input logic [sbr_pkg::CFG_W-1:0] guard,
                            input bit poke_unused);
    finish_frames();
    drain();
    write_reg(sbr_pkg::CFG_START_OFFSET, start_off);
    write_reg(sbr_pkg::CFG_BIT_PERIOD, bit_per);
    write_reg(sbr_pkg::CFG_END_GUARD, guard);
    if (poke_unused) write_reg(CFG_UNUSED, sbr_pkg::CFG_W'($urandom_range(0, 32'hFFFFF)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : result_ready
    int unsigned stall;
    rx_out.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off: the result register fills and the line input stalls
        rx_out.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!tail_quiet && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        stall = $urandom_range(1, 17);
        rx_out.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        rx_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rx_out.valid === 1'b1 && rx_out.ready === 1'b1) begin
      if (bytes_due.size() == 0) begin
        $display("%0t ns: unexpected byte: expected none, actual byte %02h perr %0b",
                 $time, rx_out.rx_byte, rx_out.parity_error);
        mismatches++;
      end else begin
        got_want = bytes_due.pop_front();
        if (rx_out.rx_byte !== got_want.rx_byte) begin
          $display("%0t ns: rx_byte mismatch: expected %02h, actual %02h",
                   $time, got_want.rx_byte, rx_out.rx_byte);
          mismatches++;
        end
        if (rx_out.parity_error !== got_want.parity_error) begin
          $display("%0t ns: parity_error mismatch: expected %0b, actual %0b",
                   $time, got_want.parity_error, rx_out.parity_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_in.valid === 1'b1 && rx_in.ready === 1'b1) ||
        (rx_out.valid === 1'b1 && rx_out.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d bytes still due",
               $time, STALL_LIMIT, bytes_due.size());
      $display("FAIL serial_byte_receiver_even_parity");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  initial begin : stimulus
    dir_row_t                  row;
    sbr_pkg::sbr_result_t      typed_res;
    int                        r;
    int unsigned               rand_base;
    int unsigned               phase_no;
    int unsigned               frames;
    int unsigned               kind;
    int unsigned               late;
    logic [sbr_pkg::CFG_W-1:0] start_off;
    logic [sbr_pkg::CFG_W-1:0] bit_per;
    logic [sbr_pkg::CFG_W-1:0] guard;

    rst            <= 1'b1;
    rx_in.valid    <= 1'b0;
    rx_in.rx_level <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= sbr_pkg::CFG_START_OFFSET;
    cfg_data       <= '0;
    hold_req        = 1'b0;
    tail_quiet      = 1'b0;
    gap_pct         = 0;
    stall_pct       = 10;
    samples_sent    = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    m_phase         = RX_IDLE;
    m_ticks         = '0;
    m_bit           = '0;
    m_shift         = '0;
    m_par           = 1'b0;
    m_start_off     = sbr_pkg::START_OFFSET_RST;
    m_bit_per       = sbr_pkg::BIT_PERIOD_RST;
    m_guard         = sbr_pkg::END_GUARD_RST;

    //                 start     bit_per   guard  frm  bits     late  typed byte  perr
    dir_rows[0]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h000, 4'd0, 1'b1, 8'h00, 1'b0};
    dir_rows[1]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h1FF, 4'd0, 1'b1, 8'h00, 1'b1};
    dir_rows[2]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h1FE, 4'd0, 1'b1, 8'hFF, 1'b0};
    dir_rows[3]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h001, 4'd0, 1'b1, 8'h00, 1'b1};
    dir_rows[4]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h101, 4'd0, 1'b1, 8'h80, 1'b0};
    dir_rows[5]  = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h003, 4'd0, 1'b1, 8'h01, 1'b0};
    dir_rows[6]  = '{20'd0,   20'd0,   20'd0, 1'b1, 9'h0A5, 4'd2, 1'b0, 8'h00, 1'b0};
    dir_rows[7]  = '{20'd0,   20'd3,   20'd1, 1'b1, 9'h1AA, 4'd0, 1'b0, 8'h00, 1'b0};
    dir_rows[8]  = '{20'd2,   20'd0,   20'd3, 1'b1, 9'h055, 4'd1, 1'b0, 8'h00, 1'b0};
    dir_rows[9]  = '{20'd3,   20'd2,   20'd5, 1'b1, 9'h155, 4'd3, 1'b0, 8'h00, 1'b0};
    dir_rows[10] = '{20'd7,   20'd4,   20'd0, 1'b1, 9'h0F0, 4'd0, 1'b0, 8'h00, 1'b0};
    dir_rows[11] = '{20'd64,  20'd1,   20'd1, 1'b1, 9'h133, 4'd0, 1'b0, 8'h00, 1'b0};
    dir_rows[12] = '{20'd1,   CFG_MAX, CFG_MAX, 1'b0, 9'h000, 4'd0, 1'b0, 8'h00, 1'b0};
    dir_rows[13] = '{20'd1,   20'd1,   20'd0, 1'b1, 9'h0FF, 4'd0, 1'b1, 8'h7F, 1'b0};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      set_config(row.start_off, row.bit_per, row.guard, r == 0);
      // the long start offset runs back to back
      gap_pct = (row.start_off > 20'd32) ? 0 : 10;
      if (row.has_frame) begin
        send_frame(row.frame, row.late_stop, 1'b0, 0);
        if (row.typed && bytes_due.size() != 0) begin
          typed_res.rx_byte      = row.want_byte;
          typed_res.parity_error = row.want_perr;
          bytes_due[bytes_due.size() - 1] = typed_res;
        end
      end
      send_line(4, 1'b0);
    end

    rand_base = samples_sent;
    phase_no  = 0;
    while (samples_sent - rand_base < RAND_SAMPLES) begin
      phase_no++;
      start_off = ($urandom_range(0, 7) == 0) ? '0 : sbr_pkg::CFG_W'($urandom_range(1, 6));
      bit_per   = ($urandom_range(0, 7) == 0) ? '0 : sbr_pkg::CFG_W'($urandom_range(1, 3));
      guard     = ($urandom_range(0, 4) == 0) ? '0 : sbr_pkg::CFG_W'($urandom_range(1, 10));
      if (phase_no == 2) begin
        start_off = 20'd1;
        bit_per   = 20'd1;
      end
      set_config(start_off, bit_per, guard, $urandom_range(0, 3) == 0);
      tail_quiet = (samples_sent - rand_base) * 5 > RAND_SAMPLES * 4;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 4;
        default: gap_pct = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 3;
        default: stall_pct = 10;
      endcase
      frames = $urandom_range(4, 9);
      for (int unsigned f = 0; f < frames; f++) begin
        if (phase_no == 2 && f == 1) hold_req = 1'b1;
        if (phase_no == 3 && f == 2) drain();
        kind = $urandom_range(0, 9);
        late = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        if (kind < 7) begin
          send_frame(9'($urandom_range(0, 511)), late, $urandom_range(0, 2) == 0, 0);
        end else if (kind < 9) begin
          // abandon the frame part way; the next one starts over its tail
          send_frame(9'($urandom_range(0, 511)), late, 1'b1, $urandom_range(1, 20));
        end else begin
          send_line($urandom_range(1, 12), 1'b1);
        end
        send_line($urandom_range(0, guard + 3), $urandom_range(0, 3) == 0);
      end
    end

    finish_frames();
    drain();
    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("PASS serial_byte_receiver_even_parity");
    end else begin
      $display("FAIL serial_byte_receiver_even_parity");
    end
    $finish;
  end

endmodule
